/* hdl/lao_pkg.sv */
// ----------------------------------------------------------------------------
// lao_pkg
// Shared widths and constants for the layer alpha-over compositor.
// ----------------------------------------------------------------------------
package lao_pkg;

    // channel width and full-scale channel value
    localparam int unsigned CH_W   = 8;
    localparam logic [7:0]  CH_MAX = 8'hFF;

    // packed pixel width (four channels)
    localparam int unsigned PIX_W = 4 * CH_W;

    // blend denominator: 255*sa + da*(255-sa) <= 65025
    localparam int unsigned DEN_W = 2 * CH_W;

    // blend numerator: at most 255 times the denominator
    localparam int unsigned NUM_W = 3 * CH_W;

    // quotient width, a channel value
    localparam int unsigned QUO_W = CH_W;

    // divider iteration counter width
    localparam int unsigned CNT_W = $clog2(QUO_W);

endpackage

/* hdl/lao_div.sv */
// ----------------------------------------------------------------------------
// lao_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in one channel, so the denominator starts aligned to the top quotient bit.
// ----------------------------------------------------------------------------
module lao_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lao_pkg::NUM_W-1:0] i_num,
    input  logic [lao_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [lao_pkg::QUO_W-1:0] o_quot
);
    import lao_pkg::*;

    localparam int unsigned DSH_W = DEN_W + QUO_W - 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [DSH_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quot;

    logic [NUM_W-1:0] n_diff;
    logic             n_ge;

    // trial subtract of the shifted denominator
    always_comb begin
        n_ge   = r_rem >= NUM_W'(r_dsh);
        n_diff = r_rem - NUM_W'(r_dsh);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, {(QUO_W-1){1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            if (n_ge) begin
                r_rem <= n_diff;
            end
            r_quot <= {r_quot[QUO_W-2:0], n_ge};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hdl/layer_alpha_over_compositor.sv */
// ----------------------------------------------------------------------------
// layer_alpha_over_compositor
// Porter-Duff source-over of straight-alpha RGBA8 layers, bottom layer first.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one layer word: packed pixel
//   (red in 31:24, alpha in 7:0), visible flag, first and last marks. A first
//   word restarts the composite from transparent zero; invisible layers leave
//   it as is. A last word emits one result word on the output channel
//   (o_valid / i_ready): composite pixel plus a covered flag (alpha nonzero).
//   One word at a time: o_ready is high only in the idle state. A visible
//   layer steps through the accepting state, a setup state for the
//   denominator and alpha, then per color channel a multiply state and a
//   wait on the shared bit-serial divider (eight steps), and a finishing
//   state. Zero source and running alpha skip the channels; an invisible
//   layer goes straight from the accepting state to the finishing state.
//   Reset clears the composite to transparent and empties the output
//   register. A result waits in the output register while the receiver
//   stalls; the block keeps taking layers, and stops only when the next
//   result is ready and the output register is still full.
// ----------------------------------------------------------------------------
module layer_alpha_over_compositor (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [lao_pkg::PIX_W-1:0] i_layer_pixel,
    input  logic                      i_layer_visible,
    input  logic                      i_first_layer,
    input  logic                      i_last_layer,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [lao_pkg::PIX_W-1:0] o_composite_pixel,
    output logic                      o_covered
);
    import lao_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [1:0] CH_FIRST = 2'd1;
    localparam logic [1:0] CH_LAST  = 2'd3;

    logic [2:0]       r_state;
    logic [PIX_W-1:0] r_src;
    logic [PIX_W-1:0] r_dst;
    logic [PIX_W-1:0] r_res;
    logic [PIX_W-1:0] r_run;
    logic             r_last;
    logic [DEN_W-1:0] r_dweight;
    logic [DEN_W-1:0] r_den;
    logic [1:0]       r_ch;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_covered;

    logic [CH_W-1:0]  n_sa;
    logic [CH_W-1:0]  n_da;
    logic [CH_W-1:0]  n_sc;
    logic [CH_W-1:0]  n_dc;
    logic [DEN_W-1:0] n_dweight;
    logic [DEN_W-1:0] n_den;
    logic [DEN_W:0]   n_alpha_sum;
    logic [DEN_W-1:0] n_ss;
    logic [NUM_W-1:0] n_num;
    logic [PIX_W-1:0] n_start_dst;
    logic             n_out_free;
    logic             div_start;
    logic             div_done;
    logic [QUO_W-1:0] div_quot;

    // channel and alpha selection
    always_comb begin
        n_sa = r_src[CH_W-1:0];
        n_da = r_dst[CH_W-1:0];
        n_sc = r_src[{r_ch, 3'b000} +: CH_W];
        n_dc = r_dst[{r_ch, 3'b000} +: CH_W];
    end

    // denominator: 255*sa + da*(255-sa), alpha = floor(den/255)
    always_comb begin
        n_dweight   = DEN_W'({8'b0, n_da} * {8'b0, CH_MAX - n_sa});
        n_den       = ({n_sa, 8'b0} - {8'b0, n_sa}) + n_dweight;
        n_alpha_sum = {1'b0, n_den} + {9'b0, n_den[DEN_W-1:CH_W]} + 17'd1;
    end

    // numerator: 255*sc*sa + dc*dweight
    always_comb begin
        n_ss  = DEN_W'({8'b0, n_sc} * {8'b0, n_sa});
        n_num = ({n_ss, 8'b0} - {8'b0, n_ss})
              + NUM_W'({16'b0, n_dc} * {8'b0, r_dweight});
    end

    assign n_start_dst = i_first_layer ? '0 : r_run;
    assign n_out_free  = !r_out_valid || i_ready;
    assign div_start   = (r_state == S_MUL);

    // shared divider
    lao_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= i_layer_visible ? S_PREP : S_FIN;
                    end
                end
                S_PREP: begin
                    r_state <= (n_den == '0) ? S_FIN : S_MUL;
                end
                S_MUL: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_state <= (r_ch == CH_LAST) ? S_FIN : S_MUL;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_run   <= r_res;
                        r_state <= S_IDLE;
                    end else if (n_out_free) begin
                        r_run       <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_src  <= i_layer_pixel;
                    r_dst  <= n_start_dst;
                    r_res  <= n_start_dst;
                    r_last <= i_last_layer;
                end
            end
            S_PREP: begin
                r_dweight <= n_dweight;
                r_den     <= n_den;
                r_ch      <= CH_FIRST;
                if (n_den == '0) begin
                    r_res <= '0;
                end else begin
                    r_res[CH_W-1:0] <= n_alpha_sum[2*CH_W-1:CH_W];
                end
            end
            S_WAIT: begin
                if (div_done) begin
                    r_res[{r_ch, 3'b000} +: CH_W] <= div_quot;
                    r_ch <= r_ch + 1'b1;
                end
            end
            S_FIN: begin
                if (r_last && n_out_free) begin
                    r_out_pixel   <= r_res;
                    r_out_covered <= (r_res[CH_W-1:0] != '0);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_composite_pixel = r_out_pixel;
    assign o_covered         = r_out_covered;

endmodule
